[sv/lht_pkg.sv]
// Package with the shared constants and types of the learned hysteresis thermostat.
`default_nettype none

package lht_pkg;

  // Offset between the captured sample and the new threshold.
  localparam int unsigned CAPTURE_OFFSET = 5;
  // Smallest gap kept between the on and off levels after a capture.
  localparam int unsigned LEVEL_GAP = 10;
  // Amount by which a held press widens the gap at each phase-zero look.
  localparam int unsigned WIDEN_STEP = 10;

  // Per-beat indicator flags that travel from the core to the output port.
  typedef struct packed {
    logic led;
    logic save;
  } lht_flags_t;

endpackage

`default_nettype wire

[sv/learned_hysteresis_thermostat_unit.sv]
// Top level of the learned hysteresis thermostat: stream ports, input stage and core.
`default_nettype none

// Learned hysteresis thermostat. Each input beat carries one temperature
// sample and the button level; each produces exactly one result beat with the
// heater pin, LED, hysteresis mode, both thresholds, the running minimum and
// maximum, and a save strobe that marks a fresh threshold capture (storing the
// levels is left to the system). A beat passes an input register, then one
// pass of compare and add logic that writes the state registers, which double
// as the result register. Throughput is one beat per clock cycle while the
// output side takes results. The accepting edge loads the input register, and
// the state registers are written when the held beat advances into them. The
// pace is set by the single update of the thermostat state registers per beat.
// The input side keeps accepting while a finished result waits on the output
// side, until the input register is also full. No clearing pass is needed
// after reset.
module learned_hysteresis_thermostat_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_BITS  = 3
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          s_tvalid,
  output logic                                               s_tready,
  // Fields from bit 0 up: temperature_code, button_pressed, zero padding.
  input  wire logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0]      s_tdata,
  output logic                                               m_tvalid,
  input  wire logic                                          m_tready,
  // Fields from bit 0 up: heater_out, led_out, heating_out, on_level_out,
  // off_level_out, lowest_out, highest_out, save_levels, zero padding.
  output logic [((4 * SAMPLE_BITS + 11) / 8) * 8 - 1:0]      m_tdata
);
  import lht_pkg::*;

  localparam int IN_BITS  = SAMPLE_BITS + 1;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 4 * SAMPLE_BITS + 4;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  logic                   held_valid;
  logic [SAMPLE_BITS-1:0] held_temperature;
  logic                   held_press;
  logic                   advance;
  logic                   out_valid;

  logic                   heater_drive;
  logic                   heating;
  logic [SAMPLE_BITS-1:0] on_level;
  logic [SAMPLE_BITS-1:0] off_level;
  logic [SAMPLE_BITS-1:0] lowest_seen;
  logic [SAMPLE_BITS-1:0] highest_seen;
  lht_flags_t             flags;

  // The held beat moves into the state registers whenever the result slot is
  // empty or its current beat is being taken in this cycle.
  assign advance = held_valid && (!out_valid || m_tready);

  lht_in_stage #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_in_stage (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_temperature  (s_tdata[SAMPLE_BITS-1:0]),
    .in_press        (s_tdata[SAMPLE_BITS]),
    .take            (advance),
    .held_valid      (held_valid),
    .held_temperature(held_temperature),
    .held_press      (held_press)
  );

  lht_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .temperature_code(held_temperature),
    .button_pressed  (held_press),
    .heater_drive    (heater_drive),
    .heating         (heating),
    .on_level        (on_level),
    .off_level       (off_level),
    .lowest_seen     (lowest_seen),
    .highest_seen    (highest_seen),
    .flags           (flags)
  );

  // The state registers hold the result until it is taken, since they only
  // change when the next beat advances into them.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({flags.save, highest_seen, lowest_seen,
                            off_level, on_level, heating, flags.led, heater_drive});

endmodule

`default_nettype wire

[sv/lht_core.sv]
// Thermostat state registers and the single-pass update logic for one sample.
`default_nettype none

module lht_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_BITS  = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire logic [SAMPLE_BITS-1:0] temperature_code,
  input  wire logic                   button_pressed,
  output logic                        heater_drive,
  output logic                        heating,
  output logic [SAMPLE_BITS-1:0]      on_level,
  output logic [SAMPLE_BITS-1:0]      off_level,
  output logic [SAMPLE_BITS-1:0]      lowest_seen,
  output logic [SAMPLE_BITS-1:0]      highest_seen,
  output lht_pkg::lht_flags_t         flags
);
  import lht_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] OFFSET_S = SAMPLE_BITS'(CAPTURE_OFFSET);
  localparam logic [SAMPLE_BITS-1:0] GAP_S    = SAMPLE_BITS'(LEVEL_GAP);
  localparam logic [SAMPLE_BITS-1:0] WIDEN_S  = SAMPLE_BITS'(WIDEN_STEP);

  logic [PHASE_BITS-1:0]  sample_phase;
  logic                   button_held;

  logic [PHASE_BITS-1:0]  sample_phase_next;
  logic                   button_held_next;
  logic                   heater_drive_next;
  logic                   heating_next;
  logic [SAMPLE_BITS-1:0] on_level_next;
  logic [SAMPLE_BITS-1:0] off_level_next;
  logic [SAMPLE_BITS-1:0] lowest_seen_next;
  logic [SAMPLE_BITS-1:0] highest_seen_next;
  lht_flags_t             flags_next;

  always_comb begin
    logic                   press;
    logic [SAMPLE_BITS-1:0] lim;
    press             = button_pressed;
    lim               = '0;
    button_held_next  = button_held;
    heater_drive_next = heater_drive;
    heating_next      = heating;
    on_level_next     = on_level;
    off_level_next    = off_level;
    flags_next.led    = 1'b0;
    flags_next.save   = 1'b0;

    if (sample_phase == '0) begin
      flags_next.led = 1'b1;
      // A press still held from the previous look widens the gap instead of capturing.
      if (button_held && press) begin
        if (heating) begin
          off_level_next = off_level + WIDEN_S;
        end else begin
          on_level_next = on_level - WIDEN_S;
        end
        press = 1'b0;
      end else begin
        button_held_next = 1'b0;
      end
      if (press) begin
        button_held_next = 1'b1;
        flags_next.save  = 1'b1;
        if (heating) begin
          heater_drive_next = 1'b0;
          off_level_next    = temperature_code - OFFSET_S;
          lim               = off_level_next - GAP_S;
          if (on_level > lim) begin
            on_level_next = lim;
          end
        end else begin
          heater_drive_next = 1'b1;
          on_level_next     = temperature_code + OFFSET_S;
          lim               = on_level_next + GAP_S;
          if (off_level < lim) begin
            off_level_next = lim;
          end
        end
      end
    end

    // Hysteresis; heating may switch on and off again within one sample.
    if (!heating_next && (temperature_code <= on_level_next)) begin
      heater_drive_next = 1'b1;
      heating_next      = 1'b1;
    end
    if (heating_next && (temperature_code >= off_level_next)) begin
      heater_drive_next = 1'b0;
      heating_next      = 1'b0;
    end
  end

  always_comb begin
    lowest_seen_next  = (temperature_code < lowest_seen) ? temperature_code : lowest_seen;
    highest_seen_next = (temperature_code > highest_seen) ? temperature_code : highest_seen;
    sample_phase_next = sample_phase + PHASE_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_phase <= '0;
      button_held  <= 1'b0;
      heating      <= 1'b1;
      heater_drive <= 1'b1;
      on_level     <= '0;
      off_level    <= '1;
      lowest_seen  <= '1;
      highest_seen <= '0;
      flags        <= '0;
    end else if (advance) begin
      sample_phase <= sample_phase_next;
      button_held  <= button_held_next;
      heating      <= heating_next;
      heater_drive <= heater_drive_next;
      on_level     <= on_level_next;
      off_level    <= off_level_next;
      lowest_seen  <= lowest_seen_next;
      highest_seen <= highest_seen_next;
      flags        <= flags_next;
    end
  end

  // A save strobe only comes from a phase-zero look.
  assert property (@(posedge clk) disable iff (rst) flags.save |-> flags.led)
    else $error("save strobe without phase-zero LED");

  // The running minimum never rises and the running maximum never falls.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> (lowest_seen <= $past(lowest_seen)) && (highest_seen >= $past(highest_seen)))
    else $error("running extremes moved the wrong way");

  // A capture leaves the button marked as held.
  assert property (@(posedge clk) disable iff (rst) advance |=> (!flags.save || button_held))
    else $error("capture did not mark the button held");

  // The heater pin follows the mode whenever no capture overrides it.
  assert property (@(posedge clk) disable iff (rst)
    advance && !flags_next.save |=> (heater_drive == heating) || ($past(heater_drive) == heater_drive))
    else $error("heater drive diverged from mode without a capture");

endmodule

`default_nettype wire

[sv/lht_in_stage.sv]
// Input register that holds one accepted sample beat for the update logic.
`default_nettype none

module lht_in_stage #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_temperature,
  input  wire logic                   in_press,
  input  wire logic                   take,
  output logic                        held_valid,
  output logic [SAMPLE_BITS-1:0]      held_temperature,
  output logic                        held_press
);

  // The register refills in the same cycle its beat is taken onward.
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_temperature <= in_temperature;
      held_press       <= in_press;
    end
  end

endmodule

`default_nettype wire

[bench/tb_learned_hysteresis_thermostat_unit.sv]
// Self-checking testbench for the learned hysteresis thermostat stream unit.
module tb_learned_hysteresis_thermostat_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lht_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int IN_W = 24;
  localparam int OUT_W = 72;
  // Receiver hold-off long enough to fill the unit and stall its input.
  localparam int unsigned HOLD_CYCLES = 400;
  // Cycles without any beat before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 4000;
  // Cap on printed mismatch lines.
  localparam int unsigned REPORT_CAP = 40;

  // Result fields, most significant first so the struct lines up with m_tdata.
  typedef struct packed {
    logic                save;
    logic [SAMPLE_W-1:0] highest;
    logic [SAMPLE_W-1:0] lowest;
    logic [SAMPLE_W-1:0] off_level;
    logic [SAMPLE_W-1:0] on_level;
    logic                heating;
    logic                led;
    logic                heater;
  } thermo_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // Fields from bit 0 up: temperature_code, button_pressed, zero padding.
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // Fields from bit 0 up: heater_out, led_out, heating_out, on_level_out,
  // off_level_out, lowest_out, highest_out, save_levels, zero padding.
  logic [OUT_W-1:0] m_tdata;

  learned_hysteresis_thermostat_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Thermostat state as predicted from the accepted samples, at reset values.
  logic [2:0]          look_phase = '0;
  logic                button_latched = 1'b0;
  logic                heat_mode = 1'b1;
  logic                heater_pin = 1'b1;
  logic [SAMPLE_W-1:0] on_thresh = '0;
  logic [SAMPLE_W-1:0] off_thresh = '1;
  logic [SAMPLE_W-1:0] coldest = '1;
  logic [SAMPLE_W-1:0] hottest = '0;

  thermo_result_t pending_results[$];
  int unsigned    mismatches = 0;
  logic [SAMPLE_W-1:0] last_temp = 16'd20000;

  // Written with nonblocking assignments by the test sequence.
  logic        no_idle = 1'b0;
  int unsigned hold_req = 0;

  // Advances the thermostat by one sample and returns the outputs after it.
  function automatic thermo_result_t predict_sample(input logic [SAMPLE_W-1:0] temp,
                                                    input logic button);
    thermo_result_t      r;
    logic                press;
    logic                led;
    logic                save;
    logic [SAMPLE_W-1:0] lim;
    press = button;
    led = 1'b0;
    save = 1'b0;
    if (look_phase == '0) begin
      led = 1'b1;
      // A press still down at the next look widens the gap instead.
      if (button_latched && press) begin
        if (heat_mode) begin
          off_thresh = off_thresh + SAMPLE_W'(WIDEN_STEP);
        end else begin
          on_thresh = on_thresh - SAMPLE_W'(WIDEN_STEP);
        end
        press = 1'b0;
      end else begin
        button_latched = 1'b0;
      end
      if (press) begin
        button_latched = 1'b1;
        save = 1'b1;
        if (heat_mode) begin
          heater_pin = 1'b0;
          off_thresh = temp - SAMPLE_W'(CAPTURE_OFFSET);
          lim = off_thresh - SAMPLE_W'(LEVEL_GAP);
          if (on_thresh > lim) on_thresh = lim;
        end else begin
          heater_pin = 1'b1;
          on_thresh = temp + SAMPLE_W'(CAPTURE_OFFSET);
          lim = on_thresh + SAMPLE_W'(LEVEL_GAP);
          if (off_thresh < lim) off_thresh = lim;
        end
      end
    end
    // Both switches may fire on the same sample.
    if (!heat_mode && temp <= on_thresh) begin
      heat_mode = 1'b1;
      heater_pin = 1'b1;
    end
    if (heat_mode && temp >= off_thresh) begin
      heat_mode = 1'b0;
      heater_pin = 1'b0;
    end
    if (coldest > temp) coldest = temp;
    if (hottest < temp) hottest = temp;
    look_phase = look_phase + 3'd1;
    r.save = save;
    r.highest = hottest;
    r.lowest = coldest;
    r.off_level = off_thresh;
    r.on_level = on_thresh;
    r.heating = heat_mode;
    r.led = led;
    r.heater = heater_pin;
    return r;
  endfunction

  // Temperature that tends to hover around the thresholds and the ends of range.
  function automatic logic [SAMPLE_W-1:0] pick_temperature();
    logic [SAMPLE_W-1:0] t;
    case ($urandom_range(15))
      0: t = SAMPLE_W'($urandom_range(20));
      1: t = '1 - SAMPLE_W'($urandom_range(20));
      2, 3: t = SAMPLE_W'($urandom_range(65535));
      4, 5, 6: t = last_temp + SAMPLE_W'($urandom_range(16)) - SAMPLE_W'(8);
      7, 8, 9, 10: t = on_thresh + SAMPLE_W'($urandom_range(24)) - SAMPLE_W'(12);
      default: t = off_thresh + SAMPLE_W'($urandom_range(24)) - SAMPLE_W'(12);
    endcase
    last_temp = t;
    return t;
  endfunction

  // Offers one sample, with random gaps before it, and records its prediction
  // at the edge where the beat is taken. Leaves s_tvalid high on return.
  task automatic send_sample(input logic [SAMPLE_W-1:0] temp, input logic button);
    while (!no_idle && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_W-SAMPLE_W-1){1'b0}}, button, temp};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_sample(temp, button));
  endtask

  // Stops offering and waits for every outstanding result. The queue only
  // changes at rising edges, so it is looked at on falling edges.
  task automatic wait_for_results;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Hand-picked run: capture while heating with a wrap below zero, held press
  // widening the off level past the top, release, and a capture while idle
  // that switches heating on and off again on the same sample.
  task automatic test_directed;
    logic [SAMPLE_W-1:0] temps [25] = '{
      16'd3, 16'd100, 16'd0, 16'd65533, 16'd1, 16'hAAAA, 16'h5555, 16'd65533,
      16'd4, 16'd8, 16'd65535, 16'd300, 16'd300, 16'd300, 16'd300, 16'd300,
      16'd300, 16'd65535, 16'd40000, 16'd40000, 16'd40000, 16'd40000, 16'd40000,
      16'd40000, 16'd65525};
    logic presses [25] = '{
      1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
      1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
      1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
      1'b1};
    for (int i = 0; i < 25; i++) begin
      send_sample(temps[i], presses[i]);
    end
  endtask

  // Random samples with a button that stays down or up for several beats.
  task automatic test_random(input int unsigned count);
    logic button;
    button = 1'b0;
    repeat (count) begin
      if ($urandom_range(3) == 0) button = ~button;
      send_sample(pick_temperature(), button);
    end
  endtask

  // Receiver holds off for a long stretch while samples keep coming.
  task automatic test_output_stall;
    hold_req <= hold_req + 1;
    no_idle <= 1'b1;
    test_random(40);
    no_idle <= 1'b0;
  endtask

  // Back-to-back beats on both sides.
  task automatic test_no_gaps(input int unsigned count);
    no_idle <= 1'b1;
    test_random(count);
    no_idle <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 24);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (mismatches < REPORT_CAP) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
      mismatches++;
    end
  endtask

  // Compares every result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    thermo_result_t got;
    thermo_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(thermo_result_t)-1:0];
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_CAP) begin
          $display("%0t ns: result beat with none expected, expected none, actual %h",
                   $time, got);
        end
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("heater_out", want.heater, got.heater);
        check_field("led_out", want.led, got.led);
        check_field("heating_out", want.heating, got.heating);
        check_field("on_level_out", want.on_level, got.on_level);
        check_field("off_level_out", want.off_level, got.off_level);
        check_field("lowest_out", want.lowest, got.lowest);
        check_field("highest_out", want.highest, got.highest);
        check_field("save_levels", want.save, got.save);
      end
    end
  end

  // Ends a hung run: counts cycles in which no beat moves on either side.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    // The sender pauses here until every result has come back.
    wait_for_results();
    test_output_stall();
    test_random(700);
    test_no_gaps(300);
    test_random(1000);
    wait_for_results();
    // Room for any stray beat after the last expected one.
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
